// ----- rtl/adlf_pkg.sv -----
package adlf_pkg;

  localparam int unsigned MAX_ANGLES_DEF = 2048;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned JUMP_W         = 31;
  localparam int unsigned PASS_W         = 16;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 31;

  localparam logic [JUMP_W-1:0] JUMP_RESET = JUMP_W'(65536);
  localparam logic [PASS_W-1:0] PASS_RESET = PASS_W'(1);

  localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT = 1'b1;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_UNLOAD  = 1'b1;
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PASS = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic busy;
    logic start;
    logic dir_bwd;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic              last_acc;
    logic              run_ok;
    logic [PASS_W-1:0] pass_cnt;
    logic              pend;
    logic              sweep_done;
    logic              pass_changed;
    logic              status_sent;
  } ctl_sts_t;

endpackage

// ----- rtl/adlf_in_if.sv -----
interface adlf_in_if;
  import adlf_pkg::*;

  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SAMPLE_W-1:0] sample_in;
  logic                last_in;

  modport source (output valid, output cmd, output sample_in, output last_in, input ready);
  modport sink   (input valid, input cmd, input sample_in, input last_in, output ready);
endinterface

// ----- rtl/adlf_out_if.sv -----
interface adlf_out_if;
  import adlf_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [1:0]          status;
  logic [SAMPLE_W-1:0] sample_out;
  logic                last_out;

  modport source (output valid, output kind, output status, output sample_out,
                  output last_out, input ready);
  modport sink   (input valid, input kind, input status, input sample_out,
                  input last_out, output ready);
endinterface

// ----- rtl/adlf_ram.sv -----
module adlf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/adlf_ctrl.sv -----
module adlf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adlf_pkg::ctl_sts_t  sts_i,
  output adlf_pkg::ctl_cmd_t  cmd_o
);
  import adlf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_FWD,
    S_BWD,
    S_STATUS
  } state_e;

  state_e            state_q;
  logic [PASS_W-1:0] passes_q;
  logic              start_q;
  logic              dir_bwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      passes_q  <= '0;
      start_q   <= 1'b0;
      dir_bwd_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (sts_i.last_acc) begin
            passes_q <= sts_i.pass_cnt;
            state_q  <= sts_i.run_ok ? S_PREP : S_STATUS;
          end
        end
        S_PREP: begin
          // unload still parked in the RAM read register
          if (!sts_i.pend) begin
            start_q   <= 1'b1;
            dir_bwd_q <= 1'b0;
            state_q   <= S_FWD;
          end
        end
        S_FWD: begin
          if (sts_i.sweep_done) begin
            start_q   <= 1'b1;
            dir_bwd_q <= 1'b1;
            state_q   <= S_BWD;
          end
        end
        S_BWD: begin
          if (sts_i.sweep_done) begin
            passes_q <= passes_q - PASS_W'(1);
            if (passes_q == PASS_W'(1) || !sts_i.pass_changed) begin
              state_q <= S_STATUS;
            end else begin
              start_q   <= 1'b1;
              dir_bwd_q <= 1'b0;
              state_q   <= S_FWD;
            end
          end
        end
        S_STATUS: begin
          if (sts_i.status_sent) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cmd_o.busy    = (state_q != S_IDLE);
  assign cmd_o.start   = start_q;
  assign cmd_o.dir_bwd = dir_bwd_q;
  assign cmd_o.emit    = (state_q == S_STATUS);

endmodule

// ----- rtl/adlf_datapath.sv -----
module adlf_datapath #(
  parameter int unsigned MAX_ANGLES = adlf_pkg::MAX_ANGLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  adlf_in_if.sink                           in_ch,
  adlf_out_if.source                        out_ch,
  input  logic                              cfg_we_i,
  input  logic [adlf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [adlf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  adlf_pkg::ctl_cmd_t                cmd_i,
  output adlf_pkg::ctl_sts_t                sts_o
);
  import adlf_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_ANGLES);
  localparam int unsigned CW   = $clog2(MAX_ANGLES + 1);
  localparam int unsigned CMPW = (CW > PASS_W) ? CW : PASS_W;

  // config
  logic [JUMP_W-1:0] jump_q;
  logic [PASS_W-1:0] pass_q;

  // column bookkeeping
  logic [CW-1:0] load_cnt_q;
  logic [CW-1:0] col_len_q;
  logic [CW-1:0] uptr_q;
  logic          ovf_q;
  status_e       status_q;

  // unload parked in RAM read register
  logic pend_q;
  logic pend_last_q;

  // output register
  logic                out_valid_q;
  logic                out_kind_q;
  status_e             out_status_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                out_last_q;

  // sweep engine
  logic                sw_act_q;
  logic                sw_bwd_q;
  logic [AW-1:0]       rd_idx_q;
  logic [CW-1:0]       left_q;
  logic                rv_q;
  logic                rv_last_q;
  logic [AW-1:0]       rv_addr_q;
  logic                first_q;
  logic [SAMPLE_W-1:0] cur_q;
  logic [AW-1:0]       cur_addr_q;
  logic                changed_q;

  // RAM port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic                  in_acc;
  logic                  out_free;
  logic                  ld_acc;
  logic                  ul_acc;
  logic                  ul_hit;
  logic                  fits;
  logic [CW-1:0]         new_len;
  logic                  bad_pass;
  logic                  ovf_now;
  status_e               status_now;
  logic signed [SAMPLE_W:0] floor_v;
  logic                  sw_lt;
  logic                  sw_we;
  logic                  status_sent;

  assign out_free = !out_valid_q || out_ch.ready;
  assign in_ch.ready = !cmd_i.busy && (!pend_q || out_free);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign ld_acc   = in_acc && (in_ch.cmd == CMD_LOAD);
  assign ul_acc   = in_acc && (in_ch.cmd == CMD_UNLOAD);
  assign ul_hit   = ul_acc && (uptr_q < col_len_q);

  assign fits     = (load_cnt_q < CW'(MAX_ANGLES));
  assign new_len  = load_cnt_q + CW'(fits);
  assign ovf_now  = ovf_q || !fits;
  assign bad_pass = (pass_q == '0) || (CMPW'(pass_q) >= CMPW'(new_len));

  always_comb begin
    if (ovf_now) begin
      status_now = ST_OVERFLOW;
    end else if (bad_pass) begin
      status_now = ST_BAD_PASS;
    end else begin
      status_now = ST_OK;
    end
  end

  // s[next] - jump at 33 bits, compared against the held neighbor
  assign floor_v = $signed({ram_rdata[SAMPLE_W-1], ram_rdata}) - $signed({2'b00, jump_q});
  assign sw_lt   = $signed({cur_q[SAMPLE_W-1], cur_q}) < floor_v;
  assign sw_we   = rv_q && !first_q && sw_lt;

  always_comb begin
    ram_we    = ld_acc && fits;
    ram_waddr = load_cnt_q[AW-1:0];
    ram_wdata = in_ch.sample_in;
    if (sw_we) begin
      ram_we    = 1'b1;
      ram_waddr = cur_addr_q;
      ram_wdata = floor_v[SAMPLE_W-1:0];
    end
    ram_re    = sw_act_q || ul_hit;
    ram_raddr = sw_act_q ? rd_idx_q : uptr_q[AW-1:0];
  end

  adlf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_ANGLES)
  ) u_column_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_q <= JUMP_RESET;
      pass_q <= PASS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_JUMP_LIMIT: jump_q <= cfg_data_i[JUMP_W-1:0];
        REG_PASS_COUNT: pass_q <= cfg_data_i[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      col_len_q   <= '0;
      uptr_q      <= '0;
      ovf_q       <= 1'b0;
      status_q    <= ST_OK;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      if (ld_acc) begin
        if (in_ch.last_in) begin
          col_len_q  <= new_len;
          load_cnt_q <= '0;
          ovf_q      <= 1'b0;
          uptr_q     <= '0;
          status_q   <= status_now;
        end else begin
          load_cnt_q <= new_len;
          ovf_q      <= ovf_now;
        end
      end
      if (ul_hit) begin
        uptr_q      <= uptr_q + CW'(1);
        pend_last_q <= (uptr_q + CW'(1) == col_len_q);
      end
      pend_q <= (pend_q && !out_free) || ul_hit;
    end
  end

  assign status_sent = out_free && !pend_q && cmd_i.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_STATUS;
      out_status_q <= ST_OK;
      out_sample_q <= '0;
      out_last_q   <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
      if (pend_q) begin
        out_valid_q  <= 1'b1;
        out_kind_q   <= KIND_SAMPLE;
        out_status_q <= ST_OK;
        out_sample_q <= ram_rdata;
        out_last_q   <= pend_last_q;
      end else if (cmd_i.emit) begin
        out_valid_q  <= 1'b1;
        out_kind_q   <= KIND_STATUS;
        out_status_q <= status_q;
        out_sample_q <= '0;
        out_last_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_act_q  <= 1'b0;
      sw_bwd_q  <= 1'b0;
      rd_idx_q  <= '0;
      left_q    <= '0;
      rv_q      <= 1'b0;
      rv_last_q <= 1'b0;
      first_q   <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      rv_q      <= sw_act_q;
      rv_last_q <= sw_act_q && (left_q == CW'(1));
      if (cmd_i.start) begin
        sw_act_q <= 1'b1;
        sw_bwd_q <= cmd_i.dir_bwd;
        rd_idx_q <= cmd_i.dir_bwd ? AW'(col_len_q - CW'(1)) : '0;
        left_q   <= col_len_q;
        first_q  <= 1'b1;
      end else begin
        if (sw_act_q) begin
          rd_idx_q <= sw_bwd_q ? rd_idx_q - AW'(1) : rd_idx_q + AW'(1);
          left_q   <= left_q - CW'(1);
          if (left_q == CW'(1)) begin
            sw_act_q <= 1'b0;
          end
        end
        if (rv_q) begin
          first_q <= 1'b0;
        end
      end
      if (cmd_i.start && !cmd_i.dir_bwd) begin
        changed_q <= 1'b0;
      end else if (sw_we) begin
        changed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rv_addr_q <= rd_idx_q;
    if (rv_q) begin
      cur_q      <= ram_rdata;
      cur_addr_q <= rv_addr_q;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.kind       = out_kind_q;
  assign out_ch.status     = out_status_q;
  assign out_ch.sample_out = out_sample_q;
  assign out_ch.last_out   = out_last_q;

  assign sts_o.last_acc     = ld_acc && in_ch.last_in;
  assign sts_o.run_ok       = (status_now == ST_OK);
  assign sts_o.pass_cnt     = pass_q;
  assign sts_o.pend         = pend_q;
  assign sts_o.sweep_done   = rv_q && rv_last_q;
  assign sts_o.pass_changed = changed_q || sw_we;
  assign sts_o.status_sent  = status_sent;

  a_no_item_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sw_act_q || rv_q) |-> !in_acc)
    else $error("item accepted during a sweep");

  a_sweep_addr_split: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sw_we && ram_re) |-> (ram_raddr != cur_addr_q))
    else $error("sweep reads the entry it writes");

  a_start_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !pend_q)
    else $error("sweep started over a parked unload");

  a_unload_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    uptr_q <= col_len_q)
    else $error("unload pointer past column end");

endmodule

// ----- rtl/angular_drop_limit_filter.sv -----
// channel  | dir | handshake          | payload
// in_ch    | in  | valid/ready        | cmd, sample_in, last_in
// out_ch   | out | valid/ready        | kind, status, sample_out, last_out
// cfg      | in  | cfg_we_i (no wait) | cfg_idx_i, cfg_data_i
//
// Loads and unloads are accepted one item per cycle unless in_ch is held off (by a
// run, or by a parked unload stalled on out_ch); an unload's sample passes from the
// RAM read register into the output register. The last load starts the filter: a
// valid column gets sweeps on the single column RAM read port, two sweeps a pass, up
// to pass_count passes; every run ends in the status item. in_ch is held off until then.
// Reset is asynchronous active low; no clearing pass, the column RAM is
// undefined until loaded. Stalls on out_ch hold at most one parked unload.
module angular_drop_limit_filter #(
  parameter int unsigned MAX_ANGLES = adlf_pkg::MAX_ANGLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  adlf_in_if.sink                         in_ch,
  adlf_out_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  logic [adlf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [adlf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import adlf_pkg::*;

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  adlf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (ctl_sts),
    .cmd_o  (ctl_cmd)
  );

  adlf_datapath #(
    .MAX_ANGLES (MAX_ANGLES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (ctl_cmd),
    .sts_o      (ctl_sts)
  );

endmodule
